### design/msae_pkg.sv
// Package for the mail sender address extractor: payload structs, the command
// word passed from the front end to the back end, back-end states and
// character constants. No dependencies.
`default_nettype none

package msae_pkg;

  // Input word: one header character or an end-of-line marker
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_item_t;

  // Output word: one address character with the line summary
  typedef struct packed {
    logic [7:0] addr_char;
    logic       last;
    logic       empty_res;
    logic [7:0] other_count;
    logic       overflow;
  } out_item_t;

  // Main action of a command, carried out after any replayed letters
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUT,
    ACT_RESTART,
    ACT_EMIT
  } act_e;

  // Back-end sequencing: fetch, replay broken match letters, act, stream out
  typedef enum logic [2:0] {
    BK_FETCH,
    BK_REP_A,
    BK_REP_T,
    BK_ACT,
    BK_RD,
    BK_OUT
  } back_state_e;

  // Progress through the " at " match
  localparam logic [1:0] AT_NONE  = 2'd0;
  localparam logic [1:0] AT_SPACE = 2'd1;
  localparam logic [1:0] AT_A     = 2'd2;
  localparam logic [1:0] AT_AT    = 2'd3;

  // Command word; pend is the match progress whose letters are replayed first
  typedef struct packed {
    logic [1:0] pend;
    act_e       act;
    logic [7:0] chr;
    logic [7:0] count;
  } cmd_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CNT_MAX   = 8'hFF;

endpackage

`default_nettype wire

### design/mail_sender_address_extractor_unit.sv
// Top level of the mail sender address extractor: front end, command queue
// and back end. Depends on msae_pkg, msae_front, msae_queue and msae_back.
`default_nettype none

// Feed the characters of one From header line as input words, then a word
// with line_end set. The block skips parenthesised comments, copies quoted
// text verbatim, restarts the address on '<' or ',', stops after the '>'
// that closes an angle address, drops tab, newline and lone spaces, and turns
// " at " into '@'. The end-of-line word streams out the address one character
// per output word, with last on the final one; an empty address gives a
// single word with empty_res set. other_count carries the saturating number
// of '<' and '(' seen on the line, and overflow says that characters beyond
// ADDR_MAX were dropped. Timing: the front end parses a word in the cycle it
// is accepted and pushes a command into a four-entry queue, so input keeps
// flowing while the back end is busy or the output is stalled, until the queue
// is full. The back end fetches each command, replays the letters of a broken
// " at" match in a state per letter, since the address store has a single
// write port, then acts; an end-of-line command then emits each word by a
// store read and an output register load, which waits while the consumer
// stalls. No clearing pass is needed after reset.
module mail_sender_address_extractor_unit #(
  parameter int unsigned ADDR_MAX = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msae_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msae_pkg::out_item_t out_data_o
);
  import msae_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, q_ready, q_valid, pop;

  // Parse characters and track line state
  msae_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouple parsing from store updates and output stalls
  msae_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_cmd)
  );

  // Apply commands to the address store and stream the address out
  msae_back #(
    .ADDR_MAX (ADDR_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### design/msae_front.sv
// Front end of the address extractor: parses each input word into a command.
// Depends on msae_pkg.
`default_nettype none

module msae_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msae_pkg::in_item_t in_data_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output msae_pkg::cmd_t     cmd_o
);
  import msae_pkg::*;

  logic       comment_q, comment_d;
  logic       angle_q, angle_d;
  logic       quote_q, quote_d;
  logic       stop_q, stop_d;
  logic [1:0] at_q, at_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] want;
  logic       handle;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    comment_d = comment_q;
    angle_d   = angle_q;
    quote_d   = quote_q;
    stop_d    = stop_q;
    at_d      = at_q;
    cnt_d     = cnt_q;
    handle    = 1'b0;
    want      = CH_SPACE;
    cmd_o     = '{pend: AT_NONE, act: ACT_NONE, chr: in_data_i.ch, count: cnt_q};
    if (in_data_i.line_end) begin
      cmd_o.pend = at_q;
      cmd_o.act  = ACT_EMIT;
      comment_d  = 1'b0;
      angle_d    = 1'b0;
      quote_d    = 1'b0;
      stop_d     = 1'b0;
      at_d       = AT_NONE;
      cnt_d      = '0;
    end else begin
      handle = 1'b1;
      if (at_q != AT_NONE) begin
        case (at_q)
          AT_SPACE: want = CH_A;
          AT_A:     want = CH_T;
          default:  want = CH_SPACE;
        endcase
        if (in_data_i.ch == want) begin
          handle = 1'b0;
          if (at_q == AT_AT) begin
            cmd_o.act = ACT_PUT;
            cmd_o.chr = CH_AT;
            at_d      = AT_NONE;
          end else begin
            at_d = at_q + 2'd1;
          end
        end else begin
          // Miss: replay the matched letters, then treat the character normally
          at_d       = AT_NONE;
          cmd_o.pend = at_q;
        end
      end
      if (handle && !stop_q) begin
        if (comment_q) begin
          if (in_data_i.ch == CH_RPAREN) comment_d = 1'b0;
        end else if (angle_q && in_data_i.ch == CH_GT) begin
          stop_d = 1'b1;
        end else if (quote_q) begin
          if (in_data_i.ch == CH_QUOTE) quote_d = 1'b0;
          cmd_o.act = ACT_PUT;
        end else begin
          case (in_data_i.ch)
            CH_TAB, CH_NL: cmd_o.act = ACT_NONE;
            CH_SPACE: at_d = AT_SPACE;
            CH_LT: begin
              if (cnt_q != CNT_MAX) cnt_d = cnt_q + 8'd1;
              angle_d   = 1'b1;
              cmd_o.act = ACT_RESTART;
            end
            CH_LPAREN: begin
              if (cnt_q != CNT_MAX) cnt_d = cnt_q + 8'd1;
              comment_d = 1'b1;
            end
            CH_COMMA: cmd_o.act = ACT_RESTART;
            CH_QUOTE: begin
              quote_d   = 1'b1;
              cmd_o.act = ACT_PUT;
            end
            default: cmd_o.act = ACT_PUT;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q <= 1'b0;
      angle_q   <= 1'b0;
      quote_q   <= 1'b0;
      stop_q    <= 1'b0;
      at_q      <= AT_NONE;
      cnt_q     <= '0;
    end else if (push_o) begin
      comment_q <= comment_d;
      angle_q   <= angle_d;
      quote_q   <= quote_d;
      stop_q    <= stop_d;
      at_q      <= at_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/msae_queue.sv
// Short command queue between the front and back ends of the extractor.
// Depends on msae_pkg.
`default_nettype none

module msae_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msae_pkg::cmd_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output msae_pkg::cmd_t data_o
);
  import msae_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### design/msae_back.sv
// Back end of the extractor: runs commands against the address store and
// streams the address out through an output register. Depends on msae_pkg.
`default_nettype none

module msae_back #(
  parameter int unsigned ADDR_MAX = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  msae_pkg::cmd_t      q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msae_pkg::out_item_t out_data_o
);
  import msae_pkg::*;

  localparam int unsigned LEN_W = $clog2(ADDR_MAX + 1);
  localparam int unsigned IDX_W = $clog2(ADDR_MAX);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] k_q, k_d, k_next;
  logic        drop_q, drop_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [7:0]  mem_q [ADDR_MAX];
  logic [7:0]  rd_data_q;
  logic        wr_en, rd_en, app_en;
  logic [7:0]  app_data;
  logic        slot_free, is_last;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign k_next      = k_q + LEN_W'(1);
  assign is_last     = (len_q == '0) || (k_next == len_q);
  assign wr_en       = app_en && (len_q < LEN_W'(ADDR_MAX));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    k_d         = k_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    app_en      = 1'b0;
    app_data    = cmd_q.chr;
    case (state_q)
      BK_FETCH: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = q_data_i;
          state_d = (q_data_i.pend >= AT_A) ? BK_REP_A : BK_ACT;
        end
      end
      BK_REP_A: begin
        app_en   = 1'b1;
        app_data = CH_A;
        state_d  = (cmd_q.pend == AT_AT) ? BK_REP_T : BK_ACT;
      end
      BK_REP_T: begin
        app_en   = 1'b1;
        app_data = CH_T;
        state_d  = BK_ACT;
      end
      BK_ACT: begin
        state_d = BK_FETCH;
        case (cmd_q.act)
          ACT_PUT: app_en = 1'b1;
          ACT_RESTART: begin
            len_d  = '0;
            drop_d = 1'b0;
          end
          ACT_EMIT: begin
            k_d     = '0;
            state_d = BK_RD;
          end
          default: state_d = BK_FETCH;
        endcase
      end
      BK_RD: begin
        rd_en   = (len_q != '0);
        state_d = BK_OUT;
      end
      BK_OUT: begin
        // Hold the read data until the output register can take it
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.addr_char   = (len_q == '0) ? 8'd0 : rd_data_q;
          out_d.last        = is_last;
          out_d.empty_res   = (len_q == '0);
          out_d.other_count = cmd_q.count;
          out_d.overflow    = drop_q;
          if (is_last) begin
            len_d   = '0;
            drop_d  = 1'b0;
            state_d = BK_FETCH;
          end else begin
            k_d     = k_next;
            state_d = BK_RD;
          end
        end
      end
      default: state_d = BK_FETCH;
    endcase
    if (app_en) begin
      if (len_q < LEN_W'(ADDR_MAX)) len_d = len_q + LEN_W'(1);
      else drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[len_q[IDX_W-1:0]] <= app_data;
    if (rd_en) rd_data_q <= mem_q[k_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_FETCH;
      len_q       <= '0;
      k_q         <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      k_q         <= k_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(ADDR_MAX))
    else $error("address length beyond store size");
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RD && len_q != '0) |-> (k_q < len_q))
    else $error("emit index beyond address length");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT && slot_free && is_last) |=> (len_q == '0 && !drop_q))
    else $error("store not cleared after last word");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for mail_sender_address_extractor_unit: feeds From header lines as
// input words, predicts the extracted sender address and checks every output
// word. Depends on msae_pkg and the unit's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msae_pkg::*;

  localparam int ADDR_LIMIT  = 64;
  localparam int WORD_GOAL   = 480;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Shared between the sender, the receiver and the checker
  out_item_t  expected_addr_q[$];
  logic [7:0] line_buf[$];
  int         errors = 0;
  int         words_sent = 0;
  int         hold_request = 0;
  bit         no_idle = 1'b0;

  // Parser state of the header line as the unit should see it
  bit         hdr_in_comment = 1'b0;
  bit         hdr_in_angle = 1'b0;
  bit         hdr_in_quote = 1'b0;
  bit         hdr_stopped = 1'b0;
  logic [1:0] at_match = AT_NONE;
  int         addr_len = 0;
  logic [7:0] addr_buf[ADDR_LIMIT];
  logic [7:0] open_count = 8'h00;
  bit         addr_dropped = 1'b0;

  mail_sender_address_extractor_unit #(
    .ADDR_MAX(ADDR_LIMIT)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Address prediction
  // ---------------------------------------------------------------------------

  function automatic void store_char(input logic [7:0] c);
    if (addr_len < ADDR_LIMIT) begin
      addr_buf[addr_len] = c;
      addr_len++;
    end else begin
      addr_dropped = 1'b1;
    end
  endfunction

  function automatic void count_opener();
    if (open_count != CNT_MAX) open_count++;
  endfunction

  // Put back the letters of a broken " at" match as plain characters
  function automatic void replay_at(input logic [1:0] prog);
    if (prog == AT_A || prog == AT_AT) store_char(CH_A);
    if (prog == AT_AT) store_char(CH_T);
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    if (!hdr_stopped) begin
      if (hdr_in_comment) begin
        if (c == CH_RPAREN) hdr_in_comment = 1'b0;
      end else if (hdr_in_angle && c == CH_GT) begin
        hdr_stopped = 1'b1;
      end else if (hdr_in_quote) begin
        if (c == CH_QUOTE) hdr_in_quote = 1'b0;
        store_char(c);
      end else begin
        case (c)
          CH_TAB, CH_NL: ;
          CH_SPACE: at_match = AT_SPACE;
          CH_LT: begin
            count_opener();
            hdr_in_angle = 1'b1;
            addr_len = 0;
            addr_dropped = 1'b0;
          end
          CH_LPAREN: begin
            count_opener();
            hdr_in_comment = 1'b1;
          end
          CH_COMMA: begin
            addr_len = 0;
            addr_dropped = 1'b0;
          end
          CH_QUOTE: begin
            hdr_in_quote = 1'b1;
            store_char(c);
          end
          default: store_char(c);
        endcase
      end
    end
  endfunction

  // Advance the header state by one accepted word; an end-of-line word queues
  // the address words the unit must produce
  function automatic void follow_word(input in_item_t w);
    logic [1:0] prog;
    logic [7:0] want;
    bit         taken;
    out_item_t  r;
    if (!w.line_end) begin
      prog = at_match;
      taken = 1'b0;
      if (prog != AT_NONE) begin
        want = (prog == AT_SPACE) ? CH_A : (prog == AT_A) ? CH_T : CH_SPACE;
        if (w.ch == want) begin
          taken = 1'b1;
          if (prog == AT_AT) begin
            store_char(CH_AT);
            at_match = AT_NONE;
          end else begin
            at_match = prog + 2'd1;
          end
        end else begin
          at_match = AT_NONE;
          replay_at(prog);
        end
      end
      if (!taken) parse_char(w.ch);
    end else begin
      replay_at(at_match);
      at_match = AT_NONE;
      r.other_count = open_count;
      r.overflow = addr_dropped;
      if (addr_len == 0) begin
        r.addr_char = 8'h00;
        r.last = 1'b1;
        r.empty_res = 1'b1;
        expected_addr_q.push_back(r);
      end else begin
        r.empty_res = 1'b0;
        for (int k = 0; k < addr_len; k++) begin
          r.addr_char = addr_buf[k];
          r.last = (k == addr_len - 1);
          expected_addr_q.push_back(r);
        end
      end
      hdr_in_comment = 1'b0;
      hdr_in_angle = 1'b0;
      hdr_in_quote = 1'b0;
      hdr_stopped = 1'b0;
      addr_len = 0;
      open_count = 8'h00;
      addr_dropped = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one word, with an occasional gap first; valid stays high on return
  // so that a following word keeps the channel busy without a dip
  task automatic send_word(input in_item_t w);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1))
        @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    follow_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t w;
    w.ch = c;
    w.line_end = 1'b0;
    send_word(w);
  endtask

  // ch is don't-care on an end-of-line word, so fill it with rubbish
  task automatic send_eol();
    in_item_t w;
    w.ch = 8'($urandom_range(255));
    w.line_end = 1'b1;
    send_word(w);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  task automatic send_line_buf();
    foreach (line_buf[k]) send_char(line_buf[k]);
    send_eol();
  endtask

  // Hold the sender off until every predicted word has come back
  task automatic wait_drained(input int extra);
    in_valid = 1'b0;
    while (expected_addr_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Header line generation
  // ---------------------------------------------------------------------------

  // Letters a and t are frequent so that " at" matches get going often
  function automatic logic [7:0] word_char();
    string pool;
    pool = "aatbtxyz09.-_Q";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(6, 1)) line_buf.push_back(word_char());
  endfunction

  function automatic void add_token();
    int    pick;
    int    n;
    string frag;
    pick = $urandom_range(99);
    if (pick < 15) begin
      add_word();
    end else if (pick < 32) begin
      // Whole or partial " at ", sometimes broken by another character
      frag = " at ";
      n = $urandom_range(4, 1);
      for (int k = 0; k < n; k++) line_buf.push_back(frag[k]);
      if (n < 4 && $urandom_range(1) == 1) line_buf.push_back(word_char());
    end else if (pick < 44) begin
      line_buf.push_back(CH_LT);
      add_word();
      if ($urandom_range(3) != 0) begin
        line_buf.push_back(CH_AT);
        add_word();
      end
      if ($urandom_range(4) != 0) line_buf.push_back(CH_GT);
    end else if (pick < 54) begin
      line_buf.push_back(CH_QUOTE);
      repeat ($urandom_range(6)) begin
        case ($urandom_range(3))
          0:       line_buf.push_back(CH_SPACE);
          1:       line_buf.push_back(8'($urandom_range(255)));
          default: line_buf.push_back(word_char());
        endcase
      end
      if ($urandom_range(4) != 0) line_buf.push_back(CH_QUOTE);
    end else if (pick < 62) begin
      line_buf.push_back(CH_LPAREN);
      add_word();
      if ($urandom_range(2) == 0) line_buf.push_back(CH_LT);
      if ($urandom_range(4) != 0) line_buf.push_back(CH_RPAREN);
    end else if (pick < 68) begin
      line_buf.push_back(CH_COMMA);
    end else if (pick < 76) begin
      case ($urandom_range(2))
        0:       line_buf.push_back(CH_TAB);
        1:       line_buf.push_back(CH_NL);
        default: line_buf.push_back(CH_SPACE);
      endcase
    end else if (pick < 82) begin
      case ($urandom_range(2))
        0:       line_buf.push_back(CH_LT);
        1:       line_buf.push_back(CH_GT);
        default: line_buf.push_back(CH_RPAREN);
      endcase
    end else begin
      line_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_header_line(input int max_len);
    int target;
    line_buf.delete();
    target = $urandom_range(max_len);
    while (line_buf.size() < target) add_token();
  endfunction

  function automatic void build_noise_line();
    line_buf.delete();
    repeat ($urandom_range(25)) line_buf.push_back(8'($urandom_range(255)));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty line, comment, quote, comma and angle restart, stop after '>',
  // character zero and 0xFF, unfinished and complete " at "
  task automatic test_directed();
    send_eol();
    send_text("x(y)\"a\",b<");
    send_char(8'h00);
    send_char(8'hFF);
    send_text(">d");
    send_eol();
    send_text(" at");
    send_eol();
    send_text("u at v");
    send_eol();
    wait_drained(2);
  endtask

  // Overrun the address store, then clear the overflow flag with a comma
  task automatic test_store_overflow();
    line_buf.delete();
    repeat (ADDR_LIMIT + 8) line_buf.push_back(word_char());
    send_line_buf();
    line_buf.delete();
    repeat (ADDR_LIMIT + 4) line_buf.push_back(word_char());
    line_buf.push_back(CH_COMMA);
    add_word();
    send_line_buf();
    wait_drained(2);
  endtask

  // Stall the output for a long stretch while lines keep coming, so the
  // command queue fills and the unit has to drop in_ready
  task automatic test_output_backpressure();
    hold_request = 300;
    send_text("Ann <ann at host.example>");
    send_eol();
    repeat (4) begin
      build_header_line(16);
      send_line_buf();
    end
    wait_drained(2);
  endtask

  // Mostly plausible header lines, some pure noise, a few past the store size
  task automatic test_random_lines();
    int line_no;
    line_no = 0;
    while (words_sent < WORD_GOAL) begin
      no_idle = (line_no >= 8 && line_no < 22);
      if ($urandom_range(19) == 0) build_noise_line();
      else build_header_line(($urandom_range(14) == 0) ? 90 : 30);
      send_line_buf();
      line_no++;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_addr_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected address word: char %02h last %0d empty %0d count %0d ovf %0d",
                   out_data.addr_char, out_data.last, out_data.empty_res,
                   out_data.other_count, out_data.overflow);
      end else begin
        want = expected_addr_q.pop_front();
        if (out_data.addr_char !== want.addr_char || out_data.last !== want.last ||
            out_data.empty_res !== want.empty_res ||
            out_data.other_count !== want.other_count ||
            out_data.overflow !== want.overflow) begin
          errors++;
          if (errors <= 10)
            $display("address word mismatch: exp char %02h last %0d empty %0d count %0d ovf %0d, got char %02h last %0d empty %0d count %0d ovf %0d",
                     want.addr_char, want.last, want.empty_res, want.other_count,
                     want.overflow, out_data.addr_char, out_data.last,
                     out_data.empty_res, out_data.other_count, out_data.overflow);
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : run
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_store_overflow();
    test_output_backpressure();
    test_random_lines();
    // Let the last emission finish and catch any stray words after it
    wait_drained(SETTLE);
    errors += expected_addr_q.size();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
